### sv/cmse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cumulative mean and standard error: shared definitions
// Field widths, the block limit, step counts of the serial units and the
// sequencer state type.
// ----------------------------------------------------------------------------
package cmse_pkg;

	localparam int VALUE_W  = 24;
	localparam int OFFSET_W = 25;
	localparam int ERR_W    = 24;
	localparam int COUNT_W  = 13;
	localparam int SUM_W    = 36;
	localparam int SQSUM_W  = 60;
	localparam int PROD_W   = 2 * VALUE_W;
	localparam int STEP_W   = 6;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 64;

	localparam logic [COUNT_W-1:0] MAX_BLOCKS = 13'd4096;

	localparam logic [STEP_W-1:0] DIV_LAST  = 6'(SQSUM_W - 1);
	localparam logic [STEP_W-1:0] MUL_LAST  = 6'(VALUE_W - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = 6'(ERR_W - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_DIV_MEAN,
		ST_DIV_MSQ,
		ST_MUL_MEAN,
		ST_DIV_VAR,
		ST_SQRT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic load_out;
		logic step_mul;
		logic step_div;
		logic step_sqrt;
	} ctrl_t;

endpackage

### sv/cumulative_mean_standard_error.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cumulative mean and standard error of block averages
// Accumulates block averages and reports the running mean offset and its
// statistical error, computed with bit-serial arithmetic units.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on s_axis carries one signed Q8.16 block average in tdata
// and the start-of-series flag in tuser. Each input beat yields exactly one
// output beat on m_axis carrying the mean offset, the standard error and the
// block count in tdata and the dropped flag in tuser.
// The reference value is written through cfg_we and cfg_wdata; the user must
// write it only while idle, since the block itself has no guard for it.
// One item is processed at a time. A serial shift-add multiplier squares the
// value, a restoring divider producing one quotient bit per cycle forms the
// mean and the mean square, the multiplier squares the mean, the divider
// scales the variance and a serial square root takes in two radicand bits
// per cycle. When the count is one, the squaring of the mean, the variance
// division and the square root are skipped. The next input beat is taken
// once the result is loaded into the result register. The result register
// holds one beat, so a new item is accepted while the previous result waits;
// a stalled receiver holds the block only when a second result is finished.
// Reset clears the count, the sums and the reference value.
module cumulative_mean_standard_error (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cmse_pkg::VALUE_W-1:0]          cfg_wdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// block_value [23:0]
	input  logic [cmse_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// start_series [0]
	input  logic [0:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// mean_offset [24:0], std_error [48:25], blocks_seen [61:49], zero [63:62]
	output logic [cmse_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// dropped [0]
	output logic [0:0]                            m_axis_tuser
);

	localparam int VW = cmse_pkg::VALUE_W;
	localparam int CW = cmse_pkg::COUNT_W;
	localparam int SW = cmse_pkg::SUM_W;
	localparam int QW = cmse_pkg::SQSUM_W;
	localparam int PW = cmse_pkg::PROD_W;
	localparam int EW = cmse_pkg::ERR_W;
	localparam int OW = cmse_pkg::OFFSET_W;

	cmse_pkg::state_t state_q, state_nx;
	cmse_pkg::ctrl_t  ctrl;

	logic [VW-1:0]            ref_q;
	logic [CW-1:0]            count_q;
	logic signed [SW-1:0]     sum_q;
	logic [QW-1:0]            sqsum_q;

	logic                     start_q;
	logic signed [VW-1:0]     value_q;
	logic                     drop_q;
	logic                     neg_q;
	logic signed [VW-1:0]     mean_q;
	logic [PW-2:0]            meansq_q;
	logic [EW-1:0]            err_q;
	logic [cmse_pkg::STEP_W-1:0] step_q;

	logic [VW-1:0]            mul_a_q;
	logic [PW-1:0]            prod_q;
	logic [QW-1:0]            dvd_q;
	logic [CW:0]              rem_q;
	logic [CW-1:0]            div_q;
	logic [EW+2:0]            srem_q;
	logic [EW-1:0]            root_q;

	logic                     m_valid_q;
	logic [OW-1:0]            out_offset_q;
	logic [EW-1:0]            out_err_q;
	logic [CW-1:0]            out_count_q;
	logic                     out_drop_q;

	logic                     out_free;
	logic                     step_end;
	logic                     in_fire;

	logic [VW-1:0]            in_abs;
	logic [CW-1:0]            base_count;
	logic signed [SW-1:0]     base_sum;
	logic [QW-1:0]            base_sqsum;
	logic                     full;
	logic [CW-1:0]            new_count;
	logic signed [SW-1:0]     new_sum;
	logic [QW-1:0]            new_sqsum;
	logic [SW-1:0]            new_sum_abs;

	logic [VW:0]              mul_sum;
	logic [CW:0]              rem_sh;
	logic                     div_ge;
	logic [EW+2:0]            srem_sh;
	logic [EW+2:0]            trial;
	logic                     sqrt_ge;

	logic [VW-1:0]            mean_abs;
	logic signed [PW:0]       var_diff;
	logic [PW-1:0]            var_val;
	logic signed [OW-1:0]     offset_val;

	assign out_free = !m_valid_q || m_axis_tready;
	assign in_fire  = s_axis_tvalid && ctrl.in_ready;

	always_comb begin
		case (state_q)
			cmse_pkg::ST_SQUARE:   step_end = (step_q == cmse_pkg::MUL_LAST);
			cmse_pkg::ST_MUL_MEAN: step_end = (step_q == cmse_pkg::MUL_LAST);
			cmse_pkg::ST_DIV_MEAN: step_end = (step_q == cmse_pkg::DIV_LAST);
			cmse_pkg::ST_DIV_MSQ:  step_end = (step_q == cmse_pkg::DIV_LAST);
			cmse_pkg::ST_DIV_VAR:  step_end = (step_q == cmse_pkg::DIV_LAST);
			cmse_pkg::ST_SQRT:     step_end = (step_q == cmse_pkg::SQRT_LAST);
			default:               step_end = 1'b0;
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			cmse_pkg::ST_IDLE: begin
				if (s_axis_tvalid) state_nx = cmse_pkg::ST_SQUARE;
			end
			cmse_pkg::ST_SQUARE: begin
				if (step_end) state_nx = cmse_pkg::ST_ACCUM;
			end
			cmse_pkg::ST_ACCUM: begin
				state_nx = cmse_pkg::ST_DIV_MEAN;
			end
			cmse_pkg::ST_DIV_MEAN: begin
				if (step_end) state_nx = cmse_pkg::ST_DIV_MSQ;
			end
			cmse_pkg::ST_DIV_MSQ: begin
				if (step_end) begin
					state_nx = (count_q == CW'(1)) ? cmse_pkg::ST_DONE
						: cmse_pkg::ST_MUL_MEAN;
				end
			end
			cmse_pkg::ST_MUL_MEAN: begin
				if (step_end) state_nx = cmse_pkg::ST_DIV_VAR;
			end
			cmse_pkg::ST_DIV_VAR: begin
				if (step_end) state_nx = cmse_pkg::ST_SQRT;
			end
			cmse_pkg::ST_SQRT: begin
				if (step_end) state_nx = cmse_pkg::ST_DONE;
			end
			cmse_pkg::ST_DONE: begin
				if (out_free) state_nx = cmse_pkg::ST_IDLE;
			end
			default: state_nx = cmse_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			cmse_pkg::ST_IDLE:     ctrl.in_ready  = 1'b1;
			cmse_pkg::ST_SQUARE:   ctrl.step_mul  = 1'b1;
			cmse_pkg::ST_MUL_MEAN: ctrl.step_mul  = 1'b1;
			cmse_pkg::ST_DIV_MEAN: ctrl.step_div  = 1'b1;
			cmse_pkg::ST_DIV_MSQ:  ctrl.step_div  = 1'b1;
			cmse_pkg::ST_DIV_VAR:  ctrl.step_div  = 1'b1;
			cmse_pkg::ST_SQRT:     ctrl.step_sqrt = 1'b1;
			cmse_pkg::ST_DONE:     ctrl.load_out  = out_free;
			default:               ctrl = '0;
		endcase
	end

	// Accumulator update, applied once the square of the value is ready.
	always_comb begin
		in_abs      = s_axis_tdata[VW-1] ? VW'(-s_axis_tdata[VW-1:0]) : s_axis_tdata[VW-1:0];
		base_count  = start_q ? '0 : count_q;
		base_sum    = start_q ? '0 : sum_q;
		base_sqsum  = start_q ? '0 : sqsum_q;
		full        = (base_count >= cmse_pkg::MAX_BLOCKS);
		new_count   = full ? base_count : base_count + CW'(1);
		new_sum     = full ? base_sum : base_sum + SW'(value_q);
		new_sqsum   = full ? base_sqsum : base_sqsum + QW'(prod_q);
		new_sum_abs = new_sum[SW-1] ? SW'(-new_sum) : SW'(new_sum);
	end

	// One step of each serial unit.
	always_comb begin
		mul_sum = {1'b0, prod_q[PW-1:VW]} + (prod_q[0] ? {1'b0, mul_a_q} : '0);
		rem_sh  = {rem_q[CW-1:0], dvd_q[QW-1]};
		div_ge  = (rem_sh >= {1'b0, div_q});
		srem_sh = {srem_q[EW:0], dvd_q[PW-1:PW-2]};
		trial   = {1'b0, root_q, 2'b01};
		sqrt_ge = (srem_sh >= trial);
	end

	// The variance is taken on the last multiplier step, from the finished product.
	always_comb begin
		mean_abs   = mean_q[VW-1] ? VW'(-mean_q) : VW'(mean_q);
		var_diff   = signed'({2'b00, meansq_q}) - signed'({1'b0, mul_sum, prod_q[VW-1:1]});
		var_val    = var_diff[PW] ? '0 : var_diff[PW-1:0];
		offset_val = OW'(mean_q) - OW'(signed'(ref_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cmse_pkg::ST_IDLE;
			ref_q     <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			sqsum_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) ref_q <= cfg_wdata;
			if (state_q == cmse_pkg::ST_ACCUM) begin
				count_q <= new_count;
				sum_q   <= new_sum;
				sqsum_q <= new_sqsum;
			end
			if (ctrl.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step_mul || ctrl.step_div || ctrl.step_sqrt) begin
			step_q <= step_end ? '0 : step_q + 1'b1;
		end
		if (ctrl.step_mul) begin
			prod_q <= {mul_sum, prod_q[VW-1:1]};
		end
		if (ctrl.step_div) begin
			if ((state_q == cmse_pkg::ST_DIV_MEAN) && step_end) begin
				dvd_q <= sqsum_q;
				rem_q <= '0;
			end else begin
				rem_q <= div_ge ? rem_sh - {1'b0, div_q} : rem_sh;
				dvd_q <= {dvd_q[QW-2:0], div_ge};
			end
		end
		if (ctrl.step_sqrt) begin
			srem_q <= sqrt_ge ? srem_sh - trial : srem_sh;
			root_q <= {root_q[EW-2:0], sqrt_ge};
			dvd_q  <= {dvd_q[QW-3:0], 2'b00};
		end

		case (state_q)
			cmse_pkg::ST_IDLE: begin
				if (in_fire) begin
					start_q <= s_axis_tuser[0];
					value_q <= s_axis_tdata[VW-1:0];
					mul_a_q <= in_abs;
					prod_q  <= {{VW{1'b0}}, in_abs};
					step_q  <= '0;
					err_q   <= '0;
				end
			end
			cmse_pkg::ST_ACCUM: begin
				drop_q <= full;
				neg_q  <= new_sum[SW-1];
				dvd_q  <= QW'(new_sum_abs);
				div_q  <= new_count;
				rem_q  <= '0;
			end
			cmse_pkg::ST_MUL_MEAN: begin
				if (step_end) begin
					dvd_q <= QW'(var_val);
					div_q <= count_q - CW'(1);
					rem_q <= '0;
				end
			end
			cmse_pkg::ST_DIV_VAR: begin
				if (step_end) begin
					srem_q <= '0;
					root_q <= '0;
				end
			end
			cmse_pkg::ST_SQRT: begin
				if (step_end) begin
					err_q <= {root_q[EW-2:0], sqrt_ge};
				end
			end
			default: begin
			end
		endcase

		// Mean square and the square of the mean need their own capture points.
		if ((state_q == cmse_pkg::ST_DIV_MSQ) && step_end) begin
			meansq_q <= {dvd_q[PW-3:0], div_ge};
			mul_a_q  <= mean_abs;
			prod_q   <= {{VW{1'b0}}, mean_abs};
		end
		if ((state_q == cmse_pkg::ST_DIV_MEAN) && step_end) begin
			mean_q <= neg_q ? VW'(-{dvd_q[VW-2:0], div_ge}) : {dvd_q[VW-2:0], div_ge};
		end

		if (ctrl.load_out) begin
			out_offset_q <= offset_val;
			out_err_q    <= err_q;
			out_count_q  <= count_q;
			out_drop_q   <= drop_q;
		end
	end

	assign s_axis_tready = ctrl.in_ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, out_count_q, out_err_q, out_offset_q};
	assign m_axis_tuser  = out_drop_q;

endmodule

### sv/cmse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cumulative mean and standard error: port checker
// Watches the ports of the top level, bound to every instance of it, and
// flags handshake violations and results that the block can never produce.
// ----------------------------------------------------------------------------
module cmse_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_axis_tvalid,
	input logic                                  s_axis_tready,
	input logic                                  m_axis_tvalid,
	input logic                                  m_axis_tready,
	input logic [cmse_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	input logic [0:0]                            m_axis_tuser
);

	logic [cmse_pkg::COUNT_W-1:0] seen;
	logic [cmse_pkg::ERR_W-1:0]   err;

	assign seen = m_axis_tdata[61:49];
	assign err  = m_axis_tdata[48:25];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in progress");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> seen == cmse_pkg::MAX_BLOCKS)
		else $error("dropped beat below the block limit");

	a_first_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && seen == 13'd1 |-> err == '0)
		else $error("nonzero error for a single block");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> seen != '0 && err <= 24'h800000 && m_axis_tdata[63:62] == 2'b00)
		else $error("result fields out of range");

endmodule

bind cumulative_mean_standard_error cmse_checker u_cmse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cumulative mean and standard error: stream testbench
// Feeds block averages through the input stream and checks every output
// beat against a running-sum predictor of mean offset, standard error,
// block count and drop flag. A directed set covers field extremes and
// short series, random series follow under several reference values,
// and a final series runs without idling.
// ----------------------------------------------------------------------------
module testbench;

	localparam int VALUE_W    = cmse_pkg::VALUE_W;
	localparam int OFFSET_W   = cmse_pkg::OFFSET_W;
	localparam int ERR_W      = cmse_pkg::ERR_W;
	localparam int COUNT_W    = cmse_pkg::COUNT_W;
	localparam int SUM_W      = cmse_pkg::SUM_W;
	localparam int SQSUM_W    = cmse_pkg::SQSUM_W;
	localparam int IN_DATA_W  = cmse_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = cmse_pkg::OUT_DATA_W;
	localparam logic [COUNT_W-1:0] MAX_BLOCKS = cmse_pkg::MAX_BLOCKS;

	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 24'sh800000;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 24'sh7FFFFF;

	typedef struct packed {
		logic                  start;
		logic [VALUE_W-1:0]    value;
	} block_item_t;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] mean_offset;
		logic [ERR_W-1:0]           std_error;
		logic [COUNT_W-1:0]         blocks_seen;
		logic                       dropped;
	} stat_beat_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [VALUE_W-1:0]      cfg_wdata = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic [0:0]              s_axis_tuser = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	logic [0:0]              m_axis_tuser;

	block_item_t block_feed[$];
	stat_beat_t  expected_stats[$];

	logic signed [VALUE_W-1:0] ref_value = '0;
	logic [COUNT_W-1:0]        series_count = '0;
	logic signed [SUM_W-1:0]   series_sum = '0;
	logic [SQSUM_W-1:0]        series_sqsum = '0;

	int blocks_issued = 0;
	int blocks_taken = 0;
	int mismatch_count = 0;
	int feed_odds = 0;
	int feed_gap = 0;
	int feed_hold = 0;
	int sink_odds = 0;
	int sink_gap = 0;

	cumulative_mean_standard_error u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic [ERR_W-1:0] floor_sqrt(input longint unsigned x);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x)
				root = trial;
		end
		return ERR_W'(root);
	endfunction

	function automatic stat_beat_t accumulate_block(input logic start,
			input logic signed [VALUE_W-1:0] v);
		stat_beat_t r;
		longint n;
		longint mean_v;
		longint msq;
		longint variance;
		r.dropped = 1'b0;
		r.std_error = '0;
		if (start) begin
			series_count = '0;
			series_sum = '0;
			series_sqsum = '0;
		end
		if (series_count >= MAX_BLOCKS) begin
			r.dropped = 1'b1;
		end else begin
			series_count = series_count + 1'b1;
			series_sum = series_sum + v;
			series_sqsum = series_sqsum + SQSUM_W'(longint'(v) * longint'(v));
		end
		n = longint'(series_count);
		mean_v = longint'(series_sum) / n;
		if (n > 1) begin
			msq = longint'(series_sqsum / series_count);
			variance = msq - mean_v * mean_v;
			if (variance < 0)
				variance = 0;
			r.std_error = floor_sqrt(longint'(variance / (n - 1)));
		end
		r.mean_offset = OFFSET_W'(mean_v - longint'(ref_value));
		r.blocks_seen = series_count;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < 100)
			$display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_block(input logic start, input logic [VALUE_W-1:0] value);
		block_item_t blk;
		blk.start = start;
		blk.value = value;
		block_feed = {block_feed, blk};
		blocks_issued++;
	endtask

	task automatic set_reference(input logic [VALUE_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		ref_value = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (blocks_taken != blocks_issued || expected_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random_series();
		int len;
		int flavor;
		int spread;
		logic [VALUE_W-1:0] center;
		logic [VALUE_W-1:0] v;
		logic start;
		len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
		flavor = $urandom_range(0, 3);
		spread = 1 << $urandom_range(0, 22);
		center = VALUE_W'($urandom);
		for (int i = 0; i < len; i++) begin
			case (flavor)
				0: begin
					v = VALUE_W'($urandom);
				end
				1: begin
					v = center + VALUE_W'($urandom_range(0, 2 * spread)) - VALUE_W'(spread);
				end
				2: begin
					case ($urandom_range(0, 3))
						0: v = VALUE_MIN;
						1: v = VALUE_MAX;
						2: v = '0;
						default: v = '1;
					endcase
				end
				default: begin
					v = VALUE_W'($urandom_range(0, 511)) - VALUE_W'(256);
				end
			endcase
			if (i == 0)
				start = ($urandom_range(0, 9) != 0);
			else
				start = ($urandom_range(0, 63) == 0);
			queue_block(start, v);
		end
	endtask

	always @(posedge clk) begin : block_driver
		block_item_t blk;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_stats = {expected_stats,
					accumulate_block(s_axis_tuser[0], s_axis_tdata)};
				blocks_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (feed_gap == 0 && feed_odds != 0 && $urandom_range(0, feed_odds - 1) == 0) begin
					feed_gap = $urandom_range(1, 8);
					feed_hold = 0;
				end
				if (feed_gap > 0) begin
					feed_hold++;
					if (s_axis_tready || feed_hold > 300)
						feed_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (block_feed.size() != 0) begin
					blk = block_feed.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= blk.value;
					s_axis_tuser <= blk.start;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		stat_beat_t got;
		stat_beat_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.mean_offset = m_axis_tdata[OFFSET_W-1:0];
				got.std_error = m_axis_tdata[OFFSET_W+ERR_W-1:OFFSET_W];
				got.blocks_seen = m_axis_tdata[OFFSET_W+ERR_W+COUNT_W-1:OFFSET_W+ERR_W];
				got.dropped = m_axis_tuser[0];
				if (expected_stats.size() == 0) begin
					note_mismatch("result beat with nothing pending, blocks_seen",
						got.blocks_seen, -1);
				end else begin
					want = expected_stats.pop_front();
					if (got.mean_offset != want.mean_offset)
						note_mismatch("mean_offset", got.mean_offset, want.mean_offset);
					if (got.std_error != want.std_error)
						note_mismatch("std_error", got.std_error, want.std_error);
					if (got.blocks_seen != want.blocks_seen)
						note_mismatch("blocks_seen", got.blocks_seen, want.blocks_seen);
					if (got.dropped != want.dropped)
						note_mismatch("dropped", got.dropped, want.dropped);
				end
			end
			if (sink_gap == 0 && sink_odds != 0 && $urandom_range(0, sink_odds - 1) == 0)
				sink_gap = $urandom_range(1, 8);
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Short series and field extremes; the very first beat has no series start.
		set_reference('0);
		feed_odds = 3;
		sink_odds = 4;
		queue_block(1'b0, 24'h123456);
		queue_block(1'b0, VALUE_MIN);
		queue_block(1'b0, VALUE_MAX);
		queue_block(1'b1, VALUE_MIN);
		queue_block(1'b0, VALUE_MAX);
		queue_block(1'b1, VALUE_MAX);
		queue_block(1'b0, VALUE_MAX);
		queue_block(1'b0, VALUE_MAX);
		queue_block(1'b1, '0);
		queue_block(1'b0, '1);
		queue_block(1'b0, 24'h000001);
		queue_block(1'b0, '1);
		queue_block(1'b1, -24'sd3);
		queue_block(1'b0, -24'sd2);
		queue_block(1'b1, 24'h555555);
		queue_block(1'b0, 24'hAAAAAA);
		wait_drained();

		set_reference(VALUE_MIN);
		queue_block(1'b1, VALUE_MAX);
		queue_block(1'b0, VALUE_MAX);
		wait_drained();

		set_reference(VALUE_MAX);
		queue_block(1'b1, VALUE_MIN);
		queue_block(1'b0, VALUE_MIN);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				1: set_reference(VALUE_MAX);
				2: set_reference(VALUE_MIN);
				default: set_reference(VALUE_W'($urandom));
			endcase
			feed_odds = (p == 3) ? 0 : 3;
			sink_odds = (p == 0) ? 0 : 4;
			target = blocks_issued + 150;
			while (blocks_issued < target)
				queue_random_series();
			wait_drained();
		end

		// A final series runs with no idling on either side, then a new series restarts it.
		feed_odds = 0;
		sink_odds = 0;
		set_reference(VALUE_W'($urandom));
		queue_block(1'b1, VALUE_W'($urandom));
		for (int i = 0; i < 100; i++)
			queue_block(1'b0, ($urandom_range(0, 3) != 0) ? VALUE_MIN : VALUE_W'($urandom));
		queue_block(1'b1, VALUE_MAX);
		queue_block(1'b0, VALUE_W'($urandom));
		queue_block(1'b0, VALUE_W'($urandom));
		wait_drained();

		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
